// ===== rtl/icc_pkg.sv =====
package icc_pkg;

  typedef enum logic [3:0] {
    MODE_LOWER     = 4'd0,
    MODE_UPPER     = 4'd1,
    MODE_CAPITAL   = 4'd2,
    MODE_SNAKE     = 4'd3,
    MODE_CONST     = 4'd4,
    MODE_PATH      = 4'd5,
    MODE_BACKSLASH = 4'd6,
    MODE_SPINAL    = 4'd7,
    MODE_DOT       = 4'd8,
    MODE_TITLE     = 4'd9,
    MODE_CAMEL     = 4'd10,
    MODE_PASCAL    = 4'd11,
    MODE_ALNUM     = 4'd12
  } style_mode_e;

  localparam logic [7:0] CH_DASH       = 8'h2d;
  localparam logic [7:0] CH_DOT        = 8'h2e;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_SLASH      = 8'h2f;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5c;
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CASE_DELTA    = 8'h20;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
    logic       in_no_char;
  } icc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       out_last;
  } icc_out_t;

  // One queued operation: no byte (bare end marker), one byte or two bytes.
  typedef struct packed {
    logic       has_byte;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } icc_op_t;

  function automatic logic is_up(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5a);
  endfunction

  function automatic logic is_low(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_up(c) || is_low(c) || is_digit(c);
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] c);
    return is_up(c) ? c + CASE_DELTA : c;
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] c);
    return is_low(c) ? c - CASE_DELTA : c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_DASH) || (c == CH_DOT) || (c == CH_SPACE);
  endfunction

endpackage

// ===== rtl/icc_front.sv =====
module icc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  icc_pkg::icc_in_t in_i,
  output logic             push_o,
  output icc_pkg::icc_op_t push_op_o,
  input  logic             full_i
);
  import icc_pkg::*;

  logic [3:0] mode_q;
  logic       start_q, start_d;
  logic       cap_q, cap_d;
  logic       emitted_q, emitted_d;
  logic       accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    logic [7:0] c;
    logic [7:0] m;
    logic [7:0] s0;
    logic [7:0] s1;
    logic       first;
    logic       cap;
    logic       n_any;
    logic       n_two;

    c     = in_i.in_char;
    first = start_q;
    cap   = first ? (mode_q == MODE_TITLE) : cap_q;
    n_any = 1'b0;
    n_two = 1'b0;
    s0    = CH_NUL;
    s1    = CH_NUL;
    m     = is_sep(c) ? CH_UNDERSCORE : c;

    case (mode_q)
      MODE_LOWER: begin
        s0 = to_low(c);
        n_any = 1'b1;
      end
      MODE_UPPER: begin
        s0 = to_up(c);
        n_any = 1'b1;
      end
      MODE_CAPITAL: begin
        s0 = first ? to_up(c) : c;
        n_any = 1'b1;
      end
      MODE_SNAKE, MODE_CONST, MODE_PATH, MODE_BACKSLASH,
      MODE_SPINAL, MODE_DOT, MODE_TITLE: begin
        n_any = 1'b1;
        if (first) begin
          s0 = to_low(m);
        end else if (is_up(m)) begin
          s0 = CH_UNDERSCORE;
          s1 = to_low(m);
          n_two = 1'b1;
        end else begin
          s0 = m;
        end
        case (mode_q)
          MODE_CONST: begin
            s0 = to_up(s0);
            s1 = to_up(s1);
          end
          MODE_PATH: begin
            if (s0 == CH_UNDERSCORE) s0 = CH_SLASH;
          end
          MODE_BACKSLASH: begin
            if (s0 == CH_UNDERSCORE) s0 = CH_BACKSLASH;
          end
          MODE_SPINAL: begin
            if (s0 == CH_UNDERSCORE) s0 = CH_DASH;
          end
          MODE_DOT: begin
            if (s0 == CH_UNDERSCORE) s0 = CH_DOT;
          end
          MODE_TITLE: begin
            if (s0 == CH_UNDERSCORE) begin
              s0 = CH_SPACE;
              cap = 1'b1;
            end else if (cap) begin
              s0 = to_up(s0);
              cap = 1'b0;
            end else begin
              s0 = to_low(s0);
            end
            // The second byte of a pair is always a lowercase letter.
            if (n_two) begin
              if (cap) begin
                s1 = to_up(s1);
                cap = 1'b0;
              end else begin
                s1 = to_low(s1);
              end
            end
          end
          default: ;
        endcase
      end
      MODE_CAMEL, MODE_PASCAL: begin
        if (is_sep(c) || (c == CH_UNDERSCORE)) begin
          cap = 1'b1;
        end else if (is_alnum(c)) begin
          n_any = 1'b1;
          if (!emitted_q) begin
            s0 = (mode_q == MODE_PASCAL) ? to_up(c) : to_low(c);
          end else if (cap) begin
            s0 = to_up(c);
            cap = 1'b0;
          end else begin
            s0 = c;
          end
        end
      end
      MODE_ALNUM: begin
        if (is_alnum(c)) begin
          s0 = c;
          n_any = 1'b1;
        end
      end
      default: begin
        s0 = c;
        n_any = 1'b1;
      end
    endcase

    if (in_i.in_no_char) begin
      n_any = 1'b0;
      n_two = 1'b0;
    end

    push_op_o.has_byte = n_any;
    push_op_o.two      = n_two;
    push_op_o.b0       = s0;
    push_op_o.b1       = s1;
    push_op_o.last     = in_i.in_last;
    push_o             = accept && (n_any || in_i.in_last);

    start_d   = start_q;
    cap_d     = cap_q;
    emitted_d = emitted_q;
    if (accept) begin
      if (in_i.in_last) begin
        start_d   = 1'b1;
        cap_d     = 1'b0;
        emitted_d = 1'b0;
      end else if (!in_i.in_no_char) begin
        start_d   = 1'b0;
        cap_d     = cap;
        emitted_d = emitted_q || n_any;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_LOWER;
      start_q   <= 1'b1;
      cap_q     <= 1'b0;
      emitted_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      start_q   <= start_d;
      cap_q     <= cap_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

// ===== rtl/icc_fifo.sv =====
module icc_fifo #(
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  icc_pkg::icc_op_t push_op_i,
  output logic             full_o,
  input  logic             pop_i,
  output icc_pkg::icc_op_t head_op_o,
  output logic             empty_o
);
  import icc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  icc_op_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign head_op_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== rtl/icc_back.sv =====
module icc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  icc_pkg::icc_op_t  head_op_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output icc_pkg::icc_out_t out_o
);
  import icc_pkg::*;

  logic     valid_q, valid_d;
  logic     second_q, second_d;
  icc_out_t out_q, out_d;
  logic     load;

  assign load        = !empty_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  always_comb begin
    valid_d  = valid_q && out_stall_i;
    second_d = second_q;
    out_d    = out_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      if (!head_op_i.has_byte) begin
        out_d.out_char  = CH_NUL;
        out_d.out_valid = 1'b0;
        out_d.out_last  = 1'b1;
        pop_o           = 1'b1;
      end else if (head_op_i.two && !second_q) begin
        // First byte of a pair; the operation stays at the queue head.
        out_d.out_char  = head_op_i.b0;
        out_d.out_valid = 1'b1;
        out_d.out_last  = 1'b0;
        second_d        = 1'b1;
      end else begin
        out_d.out_char  = second_q ? head_op_i.b1 : head_op_i.b0;
        out_d.out_valid = 1'b1;
        out_d.out_last  = head_op_i.last;
        second_d        = 1'b0;
        pop_o           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== rtl/identifier_case_converter_top.sv =====
// Identifier case converter: rewrites a byte string into a naming style.
// The input channel (in_valid_i, in_stall_o, in_i) moves one beat per string
// byte; in_last marks the final beat, and in_no_char with in_last ends an
// empty string. The output channel (out_valid_o, out_stall_i, out_o) moves
// one beat per produced byte; a string whose final beat produces no byte
// gets one bare end marker (out_valid = 0, out_last = 1).
// The style is set through cfg_we_i / cfg_data_i; the user is to write it
// only while no string is in flight, which the block does not enforce. Codes
// 13 to 15 pass bytes through unchanged. Throughput: one beat per cycle in
// both directions while neither side stalls; an input byte that expands into
// an inserted separator plus a letter takes two output beats, and the
// operation queue absorbs that while input keeps flowing. The front
// classifier and its string state set the input rate; the output register
// in the back end sets the output rate.
// Reset clears the string state, selects the lower style and empties the
// queue and the output register. When the receiver stalls, the shown beat
// holds; the queue fills and in_stall_o rises only when it is full.
module identifier_case_converter_top #(
  parameter int QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  icc_pkg::icc_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output icc_pkg::icc_out_t out_o
);
  import icc_pkg::*;

  // Operations travel from the classifier to the emitter through the queue.
  logic    push;
  icc_op_t push_op;
  logic    full;
  logic    pop;
  icc_op_t head_op;
  logic    empty;

  // Front: takes input beats, tracks string state, works out the bytes.
  icc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .push_o     (push),
    .push_op_o  (push_op),
    .full_i     (full)
  );

  // Short queue that lets the two halves stall on their own.
  icc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .head_op_o (head_op),
    .empty_o   (empty)
  );

  // Back: splits each operation into output beats behind a register.
  icc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_op_i   (head_op),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// ===== verif/identifier_case_converter_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the identifier case converter.
// A short directed part walks every style once, the empty and dropped-byte
// endings, bytes at both ends of the byte range and a style switch in the
// middle of a string. A random part follows: mostly well-formed strings with
// random content in many styles, with stray empty beats and strings that end
// on an empty beat mixed in. Both channels idle at random, one stretch holds
// the output off long enough that the block fills up and stalls its input,
// and every output beat is checked against a local model of the conversion.
module testbench;
  import icc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [3:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  icc_in_t   in_i;
  logic      out_valid_o;
  logic      out_stall_i;
  icc_out_t  out_o;

  identifier_case_converter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  // Model state: the selected style and the per-string flags.
  logic [3:0] style;
  logic       str_start;
  logic       cap_pend;
  logic       emitted;

  // Converted bytes that the block still owes, oldest first.
  icc_out_t   expected_bytes[$];

  int         fail_count;
  int         beats_sent;
  int         strings_sent;
  int         bytes_checked;
  int         cycle_count;
  logic [15:0] styles_seen;

  // Pacing controls shared by the sender and the receiver.
  logic       idle_en;
  logic       hold_req;

  icc_out_t   want;

  // The clock runs free with a 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ASCII character classes, kept local to the bench.
  function automatic logic is_upper_ch(input logic [7:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic is_lower_ch(input logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic is_alnum_ch(input logic [7:0] c);
    return is_upper_ch(c) || is_lower_ch(c) || ((c >= "0") && (c <= "9"));
  endfunction

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    return is_upper_ch(c) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] upper_of(input logic [7:0] c);
    return is_lower_ch(c) ? c - 8'd32 : c;
  endfunction

  // Works out the bytes that one accepted input beat produces and queues
  // them. A final beat that produces nothing owes a bare end marker.
  function automatic void convert_beat(input icc_in_t beat);
    logic [7:0] c;
    logic [7:0] m;
    logic [7:0] x;
    logic [7:0] outb [2];
    logic       first;
    int         n;
    int         i;
    icc_out_t   r;
    c       = beat.in_char;
    n       = 0;
    outb[0] = CH_NUL;
    outb[1] = CH_NUL;
    if (!beat.in_no_char) begin
      first = str_start;
      if (first) begin
        cap_pend  = (style == MODE_TITLE);
        str_start = 1'b0;
      end
      case (style)
        MODE_LOWER: begin
          outb[0] = lower_of(c);
          n = 1;
        end
        MODE_UPPER: begin
          outb[0] = upper_of(c);
          n = 1;
        end
        MODE_CAPITAL: begin
          outb[0] = first ? upper_of(c) : c;
          n = 1;
        end
        MODE_SNAKE, MODE_CONST, MODE_PATH, MODE_BACKSLASH, MODE_SPINAL, MODE_DOT,
        MODE_TITLE: begin
          // Separators fold into the underscore before anything else.
          m = (c == CH_DASH || c == CH_DOT || c == CH_SPACE) ? CH_UNDERSCORE : c;
          if (first) begin
            outb[0] = lower_of(m);
            n = 1;
          end else if (is_upper_ch(m)) begin
            outb[0] = CH_UNDERSCORE;
            outb[1] = lower_of(m);
            n = 2;
          end else begin
            outb[0] = m;
            n = 1;
          end
          for (i = 0; i < n; i++) begin
            x = outb[i];
            case (style)
              MODE_CONST: x = upper_of(x);
              MODE_PATH: if (x == CH_UNDERSCORE) x = CH_SLASH;
              MODE_BACKSLASH: if (x == CH_UNDERSCORE) x = CH_BACKSLASH;
              MODE_SPINAL: if (x == CH_UNDERSCORE) x = CH_DASH;
              MODE_DOT: if (x == CH_UNDERSCORE) x = CH_DOT;
              MODE_TITLE: begin
                if (x == CH_UNDERSCORE) begin
                  cap_pend = 1'b1;
                  x = CH_SPACE;
                end else if (cap_pend) begin
                  cap_pend = 1'b0;
                  x = upper_of(x);
                end else begin
                  x = lower_of(x);
                end
              end
              default: ;
            endcase
            outb[i] = x;
          end
        end
        MODE_CAMEL, MODE_PASCAL: begin
          // The first kept byte in camel style leaves a pending capital set.
          if (c == CH_DASH || c == CH_UNDERSCORE || c == CH_DOT || c == CH_SPACE) begin
            cap_pend = 1'b1;
          end else if (is_alnum_ch(c)) begin
            if (!emitted) begin
              outb[0] = (style == MODE_PASCAL) ? upper_of(c) : lower_of(c);
            end else if (cap_pend) begin
              outb[0] = upper_of(c);
              cap_pend = 1'b0;
            end else begin
              outb[0] = c;
            end
            n = 1;
          end
        end
        MODE_ALNUM: begin
          if (is_alnum_ch(c)) begin
            outb[0] = c;
            n = 1;
          end
        end
        default: begin
          outb[0] = c;
          n = 1;
        end
      endcase
      if (n > 0) emitted = 1'b1;
    end
    if (beat.in_last && n == 0) begin
      r = '{out_char: CH_NUL, out_valid: 1'b0, out_last: 1'b1};
      expected_bytes.push_back(r);
    end else begin
      for (i = 0; i < n; i++) begin
        r = '{out_char: outb[i], out_valid: 1'b1, out_last: beat.in_last && (i == n - 1)};
        expected_bytes.push_back(r);
      end
    end
    if (beat.in_last) begin
      str_start = 1'b1;
      cap_pend  = 1'b0;
      emitted   = 1'b0;
    end
  endfunction

  // Sends one input beat. Called and returning at a falling edge, with the
  // valid low again on return so that nothing is accepted twice.
  task automatic send_beat(input logic [7:0] ch, input logic last, input logic no_char);
    int     gap;
    icc_in_t beat;
    gap  = idle_en ? $urandom_range(0, 8) : 0;
    beat = '{in_char: ch, in_last: last, in_no_char: no_char};
    in_valid_i = 1'b0;
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_i       = beat;
    do @(posedge clk_i); while (in_stall_o);
    convert_beat(beat);
    beats_sent++;
    if (last) strings_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1, 1'b0);
  endtask

  // Style writes happen only once every owed byte has come out and the
  // pipeline has had time to settle on beats that produce nothing.
  task automatic set_style(input logic [3:0] m);
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = m;
    @(posedge clk_i);
    style = m;
    styles_seen[m] = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random string content leaning on letters, digits and separators.
  function automatic logic [7:0] pick_string_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 8'($urandom_range("A", "Z"));
      3, 4:    c = 8'($urandom_range("a", "z"));
      5:       c = 8'($urandom_range("0", "9"));
      6, 7: begin
        case ($urandom_range(0, 3))
          0: c = CH_DASH;
          1: c = CH_UNDERSCORE;
          2: c = CH_DOT;
          default: c = CH_SPACE;
        endcase
      end
      8:       c = 8'($urandom_range(8'h20, 8'h7e));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // A random string, now and then with stray empty beats inside it or an
  // empty beat as its ending.
  task automatic send_random_string();
    int   len;
    int   i;
    logic end_empty;
    len       = $urandom_range(0, 10);
    end_empty = ($urandom_range(0, 7) == 0);
    if (len == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_beat(pick_string_byte(), (i == len - 1) && !end_empty, 1'b0);
      end
      if (end_empty) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
  endtask

  // The lower style is selected by reset alone, without any write.
  task automatic test_reset_style();
    styles_seen[MODE_LOWER] = 1'b1;
    send_text("Ab");
  endtask

  // One short string per style code, the three unused codes included. The
  // second byte is a capital so the snake styles insert a separator.
  task automatic test_each_style();
    int m;
    for (m = 0; m < 16; m++) begin
      set_style(4'(m));
      send_text("aQ");
    end
  endtask

  // Endings that produce nothing: an empty string, a camel string made of
  // separators only with an empty beat in its middle, bytes at both ends of
  // the range that camel drops, and the same bytes passed through in upper.
  task automatic test_empty_endings();
    set_style(MODE_CAMEL);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(CH_DASH, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(CH_DOT, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    set_style(MODE_UPPER);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
  endtask

  // The string state survives a style write; the new style applies from
  // the next byte on.
  task automatic test_style_switch_mid_string();
    set_style(MODE_TITLE);
    send_beat("k", 1'b0, 1'b0);
    set_style(MODE_CONST);
    send_text("Zz");
  endtask

  // The receiver holds off for a long stretch while capitals keep arriving
  // back to back in snake style, so the queue fills and the input stalls.
  task automatic test_backpressure();
    int i;
    set_style(MODE_SNAKE);
    idle_en  = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 40; i++) send_beat(8'($urandom_range("A", "Z")), i == 39, 1'b0);
    idle_en = 1'b1;
  endtask

  // Random strings over many style settings, the extremes included. Every
  // fifth phase runs without idling on either side.
  task automatic test_random_styles();
    int phase;
    int start;
    for (phase = 0; phase < 20; phase++) begin
      case (phase)
        0: set_style(MODE_LOWER);
        1: set_style(4'd15);
        2: set_style(MODE_ALNUM);
        3: set_style(MODE_TITLE);
        4: set_style(MODE_CAMEL);
        default: set_style(4'($urandom_range(0, 15)));
      endcase
      idle_en = (phase % 5 != 4);
      start   = beats_sent;
      while (beats_sent - start < 56) send_random_string();
    end
    idle_en = 1'b1;
  endtask

  // Output side: each beat draws its own stall, and a pending hold request
  // replaces that draw with one long stretch counted here.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      n = idle_en ? $urandom_range(0, 8) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Every beat taken from the output is compared with the oldest owed byte.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $error("Output beat with nothing owed: char %h valid %b last %b",
               out_o.out_char, out_o.out_valid, out_o.out_last);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_o.out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, out_o.out_char);
          fail_count++;
        end
        if (out_o.out_valid !== want.out_valid) begin
          $error("out_valid: expected %b, got %b", want.out_valid, out_o.out_valid);
          fail_count++;
        end
        if (out_o.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, out_o.out_last);
          fail_count++;
        end
      end
    end
  end

  // A run that hangs is stopped and counted as failed.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes still owed",
               cycle_count, expected_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = 4'd0;
    in_valid_i    = 1'b0;
    in_i          = '0;
    style         = MODE_LOWER;
    str_start     = 1'b1;
    cap_pend      = 1'b0;
    emitted       = 1'b0;
    fail_count    = 0;
    beats_sent    = 0;
    strings_sent  = 0;
    bytes_checked = 0;
    cycle_count   = 0;
    styles_seen   = '0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_style();
    test_each_style();
    test_empty_endings();
    test_style_switch_mid_string();
    test_backpressure();
    test_random_styles();

    // Let the last owed bytes come out, then give stray beats time to show.
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d input beats in %0d strings and checked %0d output beats.",
             beats_sent, strings_sent, bytes_checked);
    $display("Style codes written or active: %b, with one %0d-cycle output hold.",
             styles_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== identifier_case_converter_top.f =====
rtl/icc_pkg.sv
rtl/icc_front.sv
rtl/icc_fifo.sv
rtl/icc_back.sv
rtl/identifier_case_converter_top.sv
verif/identifier_case_converter_tb.sv
